FILE: rtl/lidfc_pkg.sv
`timescale 1ns / 1ps

package lidfc_pkg;

  localparam int unsigned PAYLOAD_W = 20;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned ID_W      = 63;

  localparam logic [3:0]           HDR_LAST_POS      = 4'd13;
  localparam logic [LEN_W-1:0]     LEN_OVERHEAD      = 32'd10;
  localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 20'h80000;

  localparam logic [7:0] VERSION_HI = 8'd0;
  localparam logic [7:0] VERSION_LO = 8'd1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_HALTED = 2'd2
  } status_t;

  // outcome of judging a complete header
  typedef struct packed {
    logic                 ok;
    logic [PAYLOAD_W-1:0] payload_len;
    logic [ID_W-1:0]      id;
  } hdr_verdict_t;

endpackage

FILE: rtl/lidfc_hdr_check.sv
`timescale 1ns / 1ps

module lidfc_hdr_check
  import lidfc_pkg::*;
(
  input  logic [LEN_W-1:0]     len_full,
  input  logic [7:0]           ver_hi,
  input  logic [7:0]           ver_lo,
  input  logic [63:0]          id_full,
  input  logic [ID_W-1:0]      last_id,
  input  logic [PAYLOAD_W-1:0] max_payload_bytes,
  output hdr_verdict_t         verdict
);

  logic [PAYLOAD_W:0] limit;
  logic [LEN_W-1:0]   payload_len_full;
  logic               len_ok;
  logic               ver_ok;
  logic               id_ok;

  always_comb begin
    limit            = {1'b0, max_payload_bytes} + LEN_OVERHEAD[PAYLOAD_W:0];
    len_ok           = (len_full > LEN_OVERHEAD) &&
                       (len_full <= {{(LEN_W-PAYLOAD_W-1){1'b0}}, limit});
    ver_ok           = (ver_hi == VERSION_HI) && (ver_lo == VERSION_LO);
    // top bit must be clear and the id must move strictly forward
    id_ok            = !id_full[63] && (id_full[ID_W-1:0] > last_id);
    payload_len_full = len_full - LEN_OVERHEAD;

    verdict.ok          = len_ok && ver_ok && id_ok;
    verdict.payload_len = payload_len_full[PAYLOAD_W-1:0];
    verdict.id          = id_full[ID_W-1:0];
  end

endmodule

FILE: rtl/length_id_frame_checker_core.sv
`timescale 1ns / 1ps

// Frame checker for a received byte stream.
// s_axis: one received byte per transaction in tdata.
// m_axis: one result per input byte. tdata carries the payload byte and the
//   frame id, tuser says whether the byte is payload and the status
//   (ok, frame rejected at this byte, halted), tlast marks the final
//   payload byte of a frame.
// cfg_wr_en/cfg_wr_data write the largest accepted payload length; write it
//   only while the stream is idle.
// Each frame is a 14-byte header (length, version 0 then 1, message id)
// followed by length - 10 payload bytes. The header is judged on its last byte.
// The result of an input transaction is in the output register in the following
// cycle; one byte is taken every cycle while the receiver accepts results.
// Reset clears the output register, returns to the header phase, sets the
// last accepted id to 1 and the payload limit to 524288.
// When the receiver stalls, the held result blocks new input only while the
// output register is full and not being drained in the same cycle.
// After the first rejected header every byte reports halted until reset.

module length_id_frame_checker_core
  import lidfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata,   // [7:0] payload_byte, [70:8] frame_id, pad
  output logic [2:0]           m_axis_tuser,   // [0] payload_valid, [2:1] status
  output logic                 m_axis_tlast,   // last_of_frame

  input  logic                 cfg_wr_en,
  input  logic [PAYLOAD_W-1:0] cfg_wr_data     // max_payload_bytes
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALTED  = 3'b100
  } phase_t;

  phase_t               phase, phase_next;
  logic [3:0]           hdr_pos, hdr_pos_next;
  logic [LEN_W-1:0]     len_acc, len_acc_next;
  logic [55:0]          id_acc, id_acc_next;
  logic [7:0]           ver_hi, ver_hi_next;
  logic [7:0]           ver_lo, ver_lo_next;
  logic [PAYLOAD_W-1:0] remaining, remaining_next;
  logic [ID_W-1:0]      last_id, last_id_next;
  logic [PAYLOAD_W-1:0] max_payload_bytes;

  logic                 out_valid;
  logic [7:0]           out_byte, out_byte_next;
  logic                 out_pvalid, out_pvalid_next;
  logic                 out_last, out_last_next;
  logic [ID_W-1:0]      out_id, out_id_next;
  status_t              out_status, out_status_next;

  logic                 in_fire;
  logic [LEN_W-1:0]     len_full;
  logic [63:0]          id_full;
  hdr_verdict_t         verdict;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // the length is complete long before the last header byte, which finishes the id
  assign len_full = len_acc;
  assign id_full  = {id_acc, s_axis_tdata};

  lidfc_hdr_check u_hdr_check (
    .len_full          (len_full),
    .ver_hi            (ver_hi),
    .ver_lo            (ver_lo),
    .id_full           (id_full),
    .last_id           (last_id),
    .max_payload_bytes (max_payload_bytes),
    .verdict           (verdict)
  );

  always_comb begin
    phase_next      = phase;
    hdr_pos_next    = hdr_pos;
    len_acc_next    = len_acc;
    id_acc_next     = id_acc;
    ver_hi_next     = ver_hi;
    ver_lo_next     = ver_lo;
    remaining_next  = remaining;
    last_id_next    = last_id;
    out_byte_next   = 8'd0;
    out_pvalid_next = 1'b0;
    out_last_next   = 1'b0;
    out_id_next     = '0;
    out_status_next = ST_OK;

    case (phase)
      PH_HALTED: begin
        out_status_next = ST_HALTED;
      end
      PH_PAYLOAD: begin
        out_byte_next   = s_axis_tdata;
        out_pvalid_next = 1'b1;
        out_id_next     = last_id;
        if (remaining <= 20'd1) begin
          out_last_next  = 1'b1;
          remaining_next = '0;
          phase_next     = PH_HEADER;
        end else begin
          remaining_next = remaining - 20'd1;
        end
      end
      PH_HEADER: begin
        if (hdr_pos < 4'd4) begin
          len_acc_next = {len_acc[23:0], s_axis_tdata};
        end else if (hdr_pos == 4'd4) begin
          ver_hi_next = s_axis_tdata;
        end else if (hdr_pos == 4'd5) begin
          ver_lo_next = s_axis_tdata;
        end else begin
          id_acc_next = id_full[55:0];
        end

        if (hdr_pos != HDR_LAST_POS) begin
          hdr_pos_next = hdr_pos + 4'd1;
        end else begin
          hdr_pos_next = '0;
          len_acc_next = '0;
          id_acc_next  = '0;
          if (verdict.ok) begin
            last_id_next   = verdict.id;
            remaining_next = verdict.payload_len;
            phase_next     = PH_PAYLOAD;
          end else begin
            phase_next      = PH_HALTED;
            out_status_next = ST_REJECT;
          end
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      hdr_pos           <= '0;
      len_acc           <= '0;
      id_acc            <= '0;
      ver_hi            <= '0;
      ver_lo            <= '0;
      remaining         <= '0;
      last_id           <= 63'd1;
      max_payload_bytes <= MAX_PAYLOAD_RESET;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_bytes <= cfg_wr_data;
      end
      if (in_fire) begin
        phase     <= phase_next;
        hdr_pos   <= hdr_pos_next;
        len_acc   <= len_acc_next;
        id_acc    <= id_acc_next;
        ver_hi    <= ver_hi_next;
        ver_lo    <= ver_lo_next;
        remaining <= remaining_next;
        last_id   <= last_id_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte   <= out_byte_next;
      out_pvalid <= out_pvalid_next;
      out_last   <= out_last_next;
      out_id     <= out_id_next;
      out_status <= out_status_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_id, out_byte};
  assign m_axis_tuser  = {out_status, out_pvalid};
  assign m_axis_tlast  = out_last;

  // a payload phase always has at least one byte left to pass
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining != '0))
    else $error("payload phase with no bytes remaining");

  // halting lasts until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALTED) |=> (phase == PH_HALTED))
    else $error("left halted state without reset");

  // accepted ids only ever grow
  a_id_increasing: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(last_id)) |-> (last_id > $past(last_id)))
    else $error("last accepted id did not increase");

  // a rejection or halt result never carries payload
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (!out_pvalid && !out_last && out_id == '0))
    else $error("payload flagged on a rejected or halted result");

  // held results do not let a new transaction overwrite them
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !in_fire)
    else $error("input taken while result held");

endmodule

FILE: tb/length_id_frame_checker_core_test.sv
`timescale 1ns / 1ps

module length_id_frame_checker_core_test;
  import lidfc_pkg::*;

  localparam logic [PAYLOAD_W-1:0] CAP_TOP = 20'hFFFFF;

  typedef enum logic {PARSE_HEADER, PARSE_PAYLOAD} parse_phase_e;
  typedef enum logic [1:0] {RX_STEADY, RX_JITTER, RX_SLUGGISH} rx_mode_e;
  typedef enum logic [2:0] {
    BAD_SHORT, BAD_LONG, BAD_VER_HI, BAD_VER_LO, BAD_ID_TOP, BAD_ID_OLD
  } header_flaw_e;

  typedef struct packed {
    logic [7:0]      payload_byte;
    logic            payload_valid;
    logic            last_of_frame;
    logic [ID_W-1:0] frame_id;
    logic [1:0]      status;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [71:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_wr_en = 1'b0;
  logic [PAYLOAD_W-1:0] cfg_wr_data = '0;

  length_id_frame_checker_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser mirror
  parse_phase_e         parse_phase = PARSE_HEADER;
  logic [3:0]           hdr_pos = '0;
  logic [LEN_W-1:0]     len_acc = '0;
  logic [63:0]          id_acc = '0;
  logic [7:0]           version_seen [2] = '{8'd0, 8'd0};
  logic [PAYLOAD_W-1:0] payload_left = '0;
  logic [ID_W-1:0]      last_id = 63'd1;
  logic                 parse_halted = 1'b0;
  logic [PAYLOAD_W-1:0] payload_cap = MAX_PAYLOAD_RESET;

  logic [7:0]    rx_stream [$];
  frame_result_t predicted_results [$];

  logic [63:0]   issued_id = 64'd1;
  logic          byte_taken = 1'b0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  rx_mode_e      rx_mode = RX_STEADY;
  int unsigned   mode_left = 0;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;

  int unsigned   mismatch_count = 0;
  int unsigned   results_seen = 0;
  int unsigned   frames_delivered = 0;
  int unsigned   payload_checked = 0;
  int unsigned   rejected_seen = 0;
  int unsigned   halted_seen = 0;
  int unsigned   cap_writes = 0;

  function automatic frame_result_t parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic [63:0]   limit;
    logic          accept;
    r = '0;
    if (parse_halted) begin
      r.status = ST_HALTED;
      return r;
    end
    if (parse_phase == PARSE_PAYLOAD) begin
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
      r.last_of_frame = (payload_left <= 1);
      r.frame_id      = last_id;
      if (r.last_of_frame) begin
        payload_left = '0;
        parse_phase  = PARSE_HEADER;
      end else begin
        payload_left = payload_left - 1'b1;
      end
      return r;
    end
    if (hdr_pos < 4)
      len_acc = {len_acc[23:0], b};
    else if (hdr_pos < 6)
      version_seen[hdr_pos[0]] = b;
    else
      id_acc = {id_acc[55:0], b};
    if (hdr_pos != HDR_LAST_POS) begin
      hdr_pos = hdr_pos + 1'b1;
      return r;
    end
    // whole header in hand: judge it
    limit  = 64'(payload_cap) + 64'(LEN_OVERHEAD);
    accept = (len_acc > LEN_OVERHEAD) && (64'(len_acc) <= limit) &&
             (version_seen[0] == VERSION_HI) && (version_seen[1] == VERSION_LO) &&
             !id_acc[63] && (id_acc[ID_W-1:0] > last_id);
    if (accept) begin
      last_id      = id_acc[ID_W-1:0];
      payload_left = PAYLOAD_W'(len_acc - LEN_OVERHEAD);
      parse_phase  = PARSE_PAYLOAD;
    end else begin
      parse_halted = 1'b1;
      r.status     = ST_REJECT;
    end
    hdr_pos = '0;
    len_acc = '0;
    id_acc  = '0;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !byte_taken) begin
      // hold the offered byte
    end else if (gap_left != 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (rx_stream.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tdata  <= rx_stream.pop_front();
      s_axis_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = 250;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY:   m_axis_tready <= 1'b1;
        RX_JITTER:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_byte  = m_axis_tdata[7:0];
        got.frame_id      = m_axis_tdata[70:8];
        got.payload_valid = m_axis_tuser[0];
        got.status        = m_axis_tuser[2:1];
        got.last_of_frame = m_axis_tlast;
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("result transaction with no byte outstanding");
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("payload_valid", want.payload_valid, got.payload_valid);
          check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
          check_field("frame_id", want.frame_id, got.frame_id);
          check_field("status", want.status, got.status);
          if (want.payload_valid) payload_checked++;
          if (want.last_of_frame) frames_delivered++;
          if (want.status == ST_REJECT) rejected_seen++;
          if (want.status == ST_HALTED) halted_seen++;
        end
      end
      byte_taken = s_axis_tvalid && s_axis_tready;
      if (byte_taken) predicted_results.push_back(parse_byte(s_axis_tdata));
    end
  end

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (rx_stream.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
  endtask

  task automatic write_payload_cap(input logic [PAYLOAD_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    payload_cap  = value;
    cap_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_header(input logic [31:0] len, input logic [7:0] v_hi,
                             input logic [7:0] v_lo, input logic [63:0] id);
    for (int i = 3; i >= 0; i--) rx_stream.push_back(len[8*i +: 8]);
    rx_stream.push_back(v_hi);
    rx_stream.push_back(v_lo);
    for (int i = 7; i >= 0; i--) rx_stream.push_back(id[8*i +: 8]);
  endtask

  task automatic push_noise(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) rx_stream.push_back(8'($urandom));
  endtask

  // well-formed frames with random sizes and rising ids
  task automatic queue_frames(input int unsigned budget, input logic [63:0] first_id);
    int unsigned pushed;
    int unsigned n;
    logic [63:0] step;
    pushed = 0;
    if (first_id > issued_id) issued_id = first_id - 1;
    while (pushed < budget) begin
      if (payload_cap <= 48)
        n = ($urandom_range(0, 3) == 0) ? payload_cap : $urandom_range(1, payload_cap);
      else
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       step = 64'd1;
        1:       step = 64'($urandom_range(1, 255));
        2:       step = 64'($urandom) + 64'd1;
        default: step = {24'd0, 8'($urandom), 32'($urandom)} + 64'd1;
      endcase
      if (pushed == 0 && first_id > issued_id) step = 64'd1;
      issued_id = issued_id + step;
      push_header(32'(n) + LEN_OVERHEAD, VERSION_HI, VERSION_LO, issued_id);
      push_noise(n);
      pushed += n + 14;
    end
  endtask

  initial begin
    header_flaw_e      flaw;
    logic [31:0]       len;
    logic [7:0]        v_hi;
    logic [7:0]        v_lo;
    logic [63:0]       id;
    logic [PAYLOAD_W-1:0] cap;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // smallest legal frame with the smallest id that can follow reset
    issued_id = 64'd2;
    push_header(32'd11, VERSION_HI, VERSION_LO, issued_id);
    rx_stream.push_back(8'hFF);
    queue_frames(260, 64'd0);

    write_payload_cap(20'd1);
    queue_frames(200, 64'd0);

    write_payload_cap(PAYLOAD_W'($urandom_range(2, 48)));
    queue_frames(260, 64'h2AAA_AAAA_AAAA_AAAA);

    write_payload_cap(CAP_TOP);
    queue_frames(260, 64'd0);

    write_payload_cap(MAX_PAYLOAD_RESET);
    queue_frames(260, 64'h5555_5555_5555_5555);

    // closing phase: one bad header, then everything after it must read halted
    case ($urandom_range(0, 4))
      0:       cap = '0;
      1:       cap = 20'd1;
      2:       cap = PAYLOAD_W'($urandom_range(2, 1000));
      3:       cap = MAX_PAYLOAD_RESET;
      default: cap = CAP_TOP;
    endcase
    write_payload_cap(cap);
    flaw = header_flaw_e'($urandom_range(0, 5));
    len  = (cap == 0) ? 32'd11 : LEN_OVERHEAD + 32'($urandom_range(1, (cap < 100) ? cap : 100));
    v_hi = VERSION_HI;
    v_lo = VERSION_LO;
    id   = issued_id + 64'd1;
    case (flaw)
      BAD_SHORT:  len = 32'($urandom_range(0, 10));
      BAD_LONG:   len = ($urandom_range(0, 1) == 0) ?
                        32'(cap) + LEN_OVERHEAD + 32'($urandom_range(1, 4)) :
                        {8'($urandom_range(1, 255)), 24'($urandom)};
      BAD_VER_HI: v_hi = 8'($urandom_range(1, 255));
      BAD_VER_LO: v_lo = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(2, 255));
      BAD_ID_TOP: id[63] = 1'b1;
      default:    id = issued_id - 64'($urandom_range(0, 3));
    endcase
    push_header(len, v_hi, v_lo, id);
    push_noise(40);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d results: %0d frames delivered with %0d payload bytes checked",
             results_seen, frames_delivered, payload_checked);
    $display("%0d limit writes, %0d header rejected (flaw %s), %0d bytes seen while halted",
             cap_writes, rejected_seen, flaw.name(), halted_seen);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: length_id_frame_checker_core.f
rtl/lidfc_pkg.sv
rtl/lidfc_hdr_check.sv
rtl/length_id_frame_checker_core.sv
tb/length_id_frame_checker_core_test.sv
